/* hdl/fcl_pkg.sv */
// Package for the field-oriented current loop: payload types, sequencer states,
// register indexes and default parameter values. No dependencies.
package fcl_pkg;

    localparam int PWM_PERIOD_DEF   = 1024;
    localparam int POLE_PAIRS_DEF   = 7;
    localparam int SINE_ENTRIES_DEF = 256;

    localparam int MAC_A_W = 19;
    localparam int MAC_B_W = 18;
    localparam int ACC_W   = 64;

    typedef struct packed {
        logic signed [15:0] current_a;
        logic signed [15:0] current_b;
        logic signed [15:0] current_c;
        logic        [15:0] rotor_angle;
        logic signed [15:0] q_target;
        logic signed [15:0] d_target;
    } in_item_t;

    typedef struct packed {
        logic        [10:0] duty_a;
        logic        [10:0] duty_b;
        logic        [10:0] duty_c;
        logic signed [15:0] d_current;
        logic signed [15:0] q_current;
    } out_item_t;

    // One command to the shared multiply-accumulate unit.
    typedef struct packed {
        logic                      en;
        logic                      load;
        logic                      shift;
        logic signed [MAC_A_W-1:0] a;
        logic signed [MAC_B_W-1:0] b;
    } mac_cmd_t;

    typedef enum logic [7:0] {
        REG_KP_Q           = 8'd0,
        REG_KI_Q           = 8'd1,
        REG_KP_D           = 8'd2,
        REG_KI_D           = 8'd3,
        REG_INTEGRAL_LIMIT = 8'd4,
        REG_VOLTAGE_LIMIT  = 8'd5,
        REG_ANGLE_OFFSET   = 8'd6,
        REG_DUTY_SCALE     = 8'd7
    } cfg_reg_t;

    typedef enum logic [5:0] {
        S_IDLE, S_SIN, S_COS, S_AL, S_BE, S_D0, S_D1, S_Q0, S_Q1, S_QE, S_ERR,
        S_PQ0, S_PQ1, S_PQ2, S_PD0, S_PD1, S_PD2,
        S_VA0, S_VA1, S_VB0, S_VB1, S_XB0, S_XB1, S_XC0, S_XC1,
        S_MM, S_SUM, S_X2, S_DA0, S_DA1, S_DB0, S_DB1, S_DC0, S_DC1, S_DONE
    } state_t;

endpackage

/* hdl/fcl_sine_rom.sv */
// Quarter-wave sine table with registered signed Q1.15 sine lookup.
// Depends on fcl_pkg.
module fcl_sine_rom import fcl_pkg::*; #(
    parameter int SineEntries = SINE_ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic [$clog2(SineEntries)+1:0]     addr,
    output logic signed [16:0]                 value
);

    localparam int LG = $clog2(SineEntries);
    localparam int PW = LG + 2;

    // Polynomial sine evaluated at elaboration for each table entry.
    function automatic logic [15:0] sine_entry(input int unsigned i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] r;
        x  = (64'd1686629713 * 64'(i)) >> LG;
        x2 = (x * x) >> 30;
        t  = 64'd1073741824;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd72;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
        r  = (((x * t) >> 30) + 64'd16384) >> 15;
        return r[15:0];
    endfunction

    logic [15:0] tbl [SineEntries];

    for (genvar g = 0; g < SineEntries; g++)
    begin : g_tbl
        assign tbl[g] = sine_entry(g);
    end

    logic [1:0]           quad;
    logic [LG-1:0]        rem;
    logic [LG:0]          idx;
    logic signed [16:0]   mag;
    logic signed [16:0]   val;

    always_comb
    begin
        quad = addr[PW-1:PW-2];
        rem  = addr[LG-1:0];
        if (quad[0])
            idx = (LG+1)'(SineEntries) - {1'b0, rem};
        else
            idx = {1'b0, rem};
        if (idx[LG])
            mag = 17'sd32768;
        else
            mag = {1'b0, tbl[idx[LG-1:0]]};
        val = quad[1] ? -mag : mag;
    end

    always_ff @(posedge clk)
    begin
        value <= val;
    end

endmodule

/* hdl/fcl_mac.sv */
// Shared signed multiply-accumulate unit with an optional 17-bit product shift.
// Depends on fcl_pkg.
module fcl_mac import fcl_pkg::*; (
    input  logic                    clk,
    input  mac_cmd_t                cmd,
    output logic signed [ACC_W-1:0] acc
);

    logic signed [MAC_A_W+MAC_B_W-1:0] prod;
    logic signed [ACC_W-1:0]           term;

    always_comb
    begin
        prod = cmd.a * cmd.b;
        term = ACC_W'(prod);
        if (cmd.shift)
            term = term <<< 17;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.en)
        begin
            if (cmd.load)
                acc <= term;
            else
                acc <= acc + term;
        end
    end

endmodule

/* hdl/field_oriented_current_loop.sv */
// Top level of the field-oriented current loop: sequencer, datapath registers
// and ports. Depends on fcl_pkg, fcl_sine_rom and fcl_mac.
//
//   Channel | Signals                        | Direction | Content
//   --------+--------------------------------+-----------+-------------------------------
//   in      | in_valid, in_ready, in_data    | input     | phase currents, angle, targets
//   out     | out_valid, out_ready, out_data | output    | three duties, d and q current
//   cfg     | cfg_valid, cfg_ready,          | input     | register index and data
//           | cfg_index, cfg_data            |           |
//
// Each input transaction runs through the sequencer steps S_SIN to S_DONE before its
// result is loaded into the output register; every multiplication of the period but the
// pole-pair scaling of the angle runs through the single multiply-accumulate unit, one
// product per cycle. in_ready is high only while the sequencer is idle. A finished result
// waits in the output register, and a new transaction can be accepted meanwhile; the
// sequencer stalls in its last step only if the previous result is still held. Reset
// returns the sequencer to idle, loads the configuration defaults and clears the
// integrators, the previous errors and out_valid at once; the datapath is not reset.
module field_oriented_current_loop import fcl_pkg::*; #(
    parameter int PWM_PERIOD   = PWM_PERIOD_DEF,
    parameter int POLE_PAIRS   = POLE_PAIRS_DEF,
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int LG = $clog2(SINE_ENTRIES);
    localparam int PW = LG + 2;

    // Configuration registers.
    logic [15:0] kp_q_reg, ki_q_reg, kp_d_reg, ki_d_reg;
    logic [14:0] ilim_reg, vlim_reg;
    logic [15:0] offset_reg, dscale_reg;

    // Sequencer and datapath registers.
    state_t             state_reg, state_next;
    in_item_t           item_reg;
    logic [PW-1:0]      p_reg;
    logic signed [16:0] sn_reg, cs_reg;
    logic signed [15:0] alpha_reg, beta_reg, dm_reg, qm_reg;
    logic signed [16:0] eq_reg, ed_reg, prev_q_reg, prev_d_reg;
    logic signed [15:0] integ_q_reg, integ_d_reg, vq_reg, vd_reg;
    logic signed [17:0] va_reg, vb_reg;
    logic signed [33:0] xb_reg, xc_reg;
    logic signed [34:0] sum_reg;
    logic signed [35:0] x2a_reg, x2b_reg, x2c_reg;
    logic [10:0]        duty_a_reg, duty_b_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    mac_cmd_t                cmd;
    logic signed [ACC_W-1:0] acc;
    logic [PW-1:0]           rom_addr;
    logic signed [16:0]      rom_val;

    fcl_sine_rom #(.SineEntries(SINE_ENTRIES)) u_rom (
        .clk   (clk),
        .addr  (rom_addr),
        .value (rom_val)
    );

    fcl_mac u_mac (
        .clk (clk),
        .cmd (cmd),
        .acc (acc)
    );

    function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] v,
                                                      input int s);
        logic signed [ACC_W-1:0] h;
        h = ACC_W'(1) <<< (s - 1);
        return (v + h) >>> s;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
        if (v > 32767)
            return 16'sh7FFF;
        else if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] clamp_abs(input logic signed [ACC_W-1:0] v,
                                                           input logic [14:0] lim);
        logic signed [ACC_W-1:0] l;
        l = ACC_W'(lim);
        if (v > l)
            return l;
        else if (v < -l)
            return -l;
        return v;
    endfunction

    // Duty from the accumulated scaled midpoint-injected phase value.
    function automatic logic [10:0] to_duty(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] d;
        d = (v >>> 40) + ACC_W'(PWM_PERIOD / 2);
        if (d < 0)
            d = '0;
        else if (d > ACC_W'(PWM_PERIOD))
            d = ACC_W'(PWM_PERIOD);
        return d[10:0];
    endfunction

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Electrical angle, then the table position with a quadrant in its top bits.
    logic [15:0] elec;
    always_comb
    begin
        elec = 16'(32'(in_data.rotor_angle) * 32'(POLE_PAIRS)) - offset_reg;
    end

    // Phase values and midpoint of the extremes.
    logic signed [33:0] xa;
    logic signed [33:0] mx, mn;
    always_comb
    begin
        xa = 34'(va_reg) <<< 15;
        mx = xa;
        if (xb_reg > mx) mx = xb_reg;
        if (xc_reg > mx) mx = xc_reg;
        mn = xa;
        if (xb_reg < mn) mn = xb_reg;
        if (xc_reg < mn) mn = xc_reg;
    end

    // Sequencer: next state and the command for the shared unit.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        rom_addr   = p_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_SIN;
            S_SIN:
            begin
                cmd = '{1'b1, 1'b1, 1'b0, 19'(item_reg.current_a), 18'sd21845};
                state_next = S_COS;
            end
            S_COS:
            begin
                rom_addr = p_reg + PW'(SINE_ENTRIES);
                cmd = '{1'b1, 1'b0, 1'b0,
                        19'(item_reg.current_b) + 19'(item_reg.current_c), -18'sd10923};
                state_next = S_AL;
            end
            S_AL:
            begin
                cmd = '{1'b1, 1'b1, 1'b0,
                        19'(item_reg.current_b) - 19'(item_reg.current_c), 18'sd18919};
                state_next = S_BE;
            end
            S_BE: state_next = S_D0;
            S_D0:
            begin
                cmd = '{1'b1, 1'b1, 1'b0, 19'(alpha_reg), 18'(cs_reg)};
                state_next = S_D1;
            end
            S_D1:
            begin
                cmd = '{1'b1, 1'b0, 1'b0, 19'(beta_reg), 18'(sn_reg)};
                state_next = S_Q0;
            end
            S_Q0:
            begin
                cmd = '{1'b1, 1'b1, 1'b0, 19'(beta_reg), 18'(cs_reg)};
                state_next = S_Q1;
            end
            S_Q1:
            begin
                cmd = '{1'b1, 1'b0, 1'b0, -19'(alpha_reg), 18'(sn_reg)};
                state_next = S_QE;
            end
            S_QE:  state_next = S_ERR;
            S_ERR: state_next = S_PQ0;
            S_PQ0:
            begin
                cmd = '{1'b1, 1'b1, 1'b0, 19'(eq_reg) + 19'(prev_q_reg), 18'({1'b0, ki_q_reg})};
                state_next = S_PQ1;
            end
            S_PQ1:
            begin
                cmd = '{1'b1, 1'b1, 1'b0, 19'(eq_reg), 18'({1'b0, kp_q_reg})};
                state_next = S_PQ2;
            end
            S_PQ2: state_next = S_PD0;
            S_PD0:
            begin
                cmd = '{1'b1, 1'b1, 1'b0, 19'(ed_reg) + 19'(prev_d_reg), 18'({1'b0, ki_d_reg})};
                state_next = S_PD1;
            end
            S_PD1:
            begin
                cmd = '{1'b1, 1'b1, 1'b0, 19'(ed_reg), 18'({1'b0, kp_d_reg})};
                state_next = S_PD2;
            end
            S_PD2: state_next = S_VA0;
            S_VA0:
            begin
                cmd = '{1'b1, 1'b1, 1'b0, 19'(vd_reg), 18'(cs_reg)};
                state_next = S_VA1;
            end
            S_VA1:
            begin
                cmd = '{1'b1, 1'b0, 1'b0, -19'(vq_reg), 18'(sn_reg)};
                state_next = S_VB0;
            end
            S_VB0:
            begin
                cmd = '{1'b1, 1'b1, 1'b0, 19'(vd_reg), 18'(sn_reg)};
                state_next = S_VB1;
            end
            S_VB1:
            begin
                cmd = '{1'b1, 1'b0, 1'b0, 19'(vq_reg), 18'(cs_reg)};
                state_next = S_XB0;
            end
            S_XB0:
            begin
                cmd = '{1'b1, 1'b1, 1'b0, 19'(va_reg), -18'sd16384};
                state_next = S_XB1;
            end
            S_XB1:
            begin
                cmd = '{1'b1, 1'b0, 1'b0, 19'(vb_reg), 18'sd28378};
                state_next = S_XC0;
            end
            S_XC0:
            begin
                cmd = '{1'b1, 1'b1, 1'b0, 19'(va_reg), -18'sd16384};
                state_next = S_XC1;
            end
            S_XC1:
            begin
                cmd = '{1'b1, 1'b0, 1'b0, 19'(vb_reg), -18'sd28378};
                state_next = S_MM;
            end
            S_MM:  state_next = S_SUM;
            S_SUM: state_next = S_X2;
            S_X2:  state_next = S_DA0;
            S_DA0:
            begin
                cmd = '{1'b1, 1'b1, 1'b1, x2a_reg[35:17], 18'({1'b0, dscale_reg})};
                state_next = S_DA1;
            end
            S_DA1:
            begin
                cmd = '{1'b1, 1'b0, 1'b0, 19'({1'b0, x2a_reg[16:0]}), 18'({1'b0, dscale_reg})};
                state_next = S_DB0;
            end
            S_DB0:
            begin
                cmd = '{1'b1, 1'b1, 1'b1, x2b_reg[35:17], 18'({1'b0, dscale_reg})};
                state_next = S_DB1;
            end
            S_DB1:
            begin
                cmd = '{1'b1, 1'b0, 1'b0, 19'({1'b0, x2b_reg[16:0]}), 18'({1'b0, dscale_reg})};
                state_next = S_DC0;
            end
            S_DC0:
            begin
                cmd = '{1'b1, 1'b1, 1'b1, x2c_reg[35:17], 18'({1'b0, dscale_reg})};
                state_next = S_DC1;
            end
            S_DC1:
            begin
                cmd = '{1'b1, 1'b0, 1'b0, 19'({1'b0, x2c_reg[16:0]}), 18'({1'b0, dscale_reg})};
                state_next = S_DONE;
            end
            S_DONE: if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_q_reg   <= '0;
            ki_q_reg   <= '0;
            kp_d_reg   <= '0;
            ki_d_reg   <= '0;
            ilim_reg   <= 15'h7FFF;
            vlim_reg   <= 15'h7FFF;
            offset_reg <= '0;
            dscale_reg <= 16'd4096;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_KP_Q:           kp_q_reg   <= cfg_data;
                REG_KI_Q:           ki_q_reg   <= cfg_data;
                REG_KP_D:           kp_d_reg   <= cfg_data;
                REG_KI_D:           ki_d_reg   <= cfg_data;
                REG_INTEGRAL_LIMIT: ilim_reg   <= cfg_data[14:0];
                REG_VOLTAGE_LIMIT:  vlim_reg   <= cfg_data[14:0];
                REG_ANGLE_OFFSET:   offset_reg <= cfg_data;
                REG_DUTY_SCALE:     dscale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Regulator state and the output valid flag.
    logic signed [ACC_W-1:0] integ_new;
    always_comb
    begin
        integ_new = '0;
        if (state_reg == S_PQ1)
            integ_new = clamp_abs(ACC_W'(integ_q_reg) + rnd(acc, 9), ilim_reg);
        else
            integ_new = clamp_abs(ACC_W'(integ_d_reg) + rnd(acc, 9), ilim_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_q_reg   <= '0;
            integ_d_reg   <= '0;
            prev_q_reg    <= '0;
            prev_d_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_PQ1) integ_q_reg <= integ_new[15:0];
            if (state_reg == S_PD1) integ_d_reg <= integ_new[15:0];
            if (state_reg == S_PQ2) prev_q_reg <= eq_reg;
            if (state_reg == S_PD2) prev_d_reg <= ed_reg;
            if (state_reg == S_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath payload registers, loaded by sequencer step.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                item_reg <= in_data;
                p_reg    <= elec[15 -: PW];
            end
            S_COS: sn_reg <= rom_val;
            S_AL:
            begin
                cs_reg    <= rom_val;
                alpha_reg <= sat16(rnd(acc, 15));
            end
            S_BE:  beta_reg <= sat16(rnd(acc, 15));
            S_Q0:  dm_reg   <= sat16(rnd(acc, 15));
            S_QE:  qm_reg   <= sat16(rnd(acc, 15));
            S_ERR:
            begin
                eq_reg <= 17'(item_reg.q_target) - 17'(qm_reg);
                ed_reg <= 17'(item_reg.d_target) - 17'(dm_reg);
            end
            S_PQ2:
            begin
                vq_reg <= 16'(clamp_abs(rnd(acc, 8) + ACC_W'(integ_q_reg), vlim_reg));
            end
            S_PD2:
            begin
                vd_reg <= 16'(clamp_abs(rnd(acc, 8) + ACC_W'(integ_d_reg), vlim_reg));
            end
            S_VB0: va_reg  <= 18'(rnd(acc, 15));
            S_XB0: vb_reg  <= 18'(rnd(acc, 15));
            S_XC0: xb_reg  <= acc[33:0];
            S_MM:  xc_reg  <= acc[33:0];
            S_SUM: sum_reg <= 35'(mx) + 35'(mn);
            S_X2:
            begin
                x2a_reg <= (36'(xa) <<< 1) - 36'(sum_reg);
                x2b_reg <= (36'(xb_reg) <<< 1) - 36'(sum_reg);
                x2c_reg <= (36'(xc_reg) <<< 1) - 36'(sum_reg);
            end
            S_DB0: duty_a_reg <= to_duty(acc);
            S_DC0: duty_b_reg <= to_duty(acc);
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_reg.duty_a    <= duty_a_reg;
                    out_reg.duty_b    <= duty_b_reg;
                    out_reg.duty_c    <= to_duty(acc);
                    out_reg.d_current <= dm_reg;
                    out_reg.q_current <= qm_reg;
                end
            end
            default: ;
        endcase
    end

endmodule
